@@ design/icd_pkg.sv @@
// Shared constants, codes and types of the interchain contact detector.
`default_nettype none

package icd_pkg;

   localparam int MAX_POINTS    = 4096;
   localparam int COORD_BITS    = 24;
   localparam int CHAIN_BITS    = 8;
   localparam int OPCODE_BITS   = 2;
   localparam int RADIUS_BITS   = 20;
   localparam int ADDR_BITS     = $clog2(MAX_POINTS);
   localparam int COUNT_BITS    = ADDR_BITS + 1;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * RADIUS_BITS;
   localparam int SUM_BITS      = SQ_BITS + 2;
   localparam int APB_ADDR_BITS = 3;
   localparam int APB_DATA_BITS = 32;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(8192);

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_RADIUS = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [CHAIN_BITS-1:0]        chain;
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } point_type;

   typedef struct packed {
      logic hit;
      logic busy;
   } pipe_status_type;

endpackage

`default_nettype wire

@@ design/icd_channels.sv @@
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface icd_req_if;
   import icd_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [OPCODE_BITS-1:0]       opcode;
   logic [CHAIN_BITS-1:0]        chain_number;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;

   modport source (output valid, opcode, chain_number, coord_x, coord_y, coord_z,
                   input ready);
   modport sink (input valid, opcode, chain_number, coord_x, coord_y, coord_z,
                 output ready);
endinterface

interface icd_rsp_if;
   logic valid;
   logic ready;
   logic in_contact;
   logic store_full;

   modport source (output valid, in_contact, store_full, input ready);
   modport sink (input valid, in_contact, store_full, output ready);
endinterface

`default_nettype wire

@@ design/icd_point_ram.sv @@
// Point store: one write port, one registered read port.
`default_nettype none

module icd_point_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [icd_pkg::ADDR_BITS-1:0] wr_addr,
   input  icd_pkg::point_type           wr_data,
   input  logic                         rd_en,
   input  logic [icd_pkg::ADDR_BITS-1:0] rd_addr,
   output icd_pkg::point_type           rd_data
);
   import icd_pkg::*;

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/icd_dist_pipe.sv @@
// Three-stage distance test of a stored point against the query point.
`default_nettype none

module icd_dist_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            flush,
   input  logic                            issue,
   input  icd_pkg::point_type              rd_data,
   input  icd_pkg::point_type              query,
   input  logic [icd_pkg::RADIUS_BITS-1:0] radius,
   input  logic [icd_pkg::SQ_BITS-1:0]     radius_sq,
   output icd_pkg::pipe_status_type        status
);
   import icd_pkg::*;

   function automatic logic [DIFF_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      logic [DIFF_BITS-1:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return d[DIFF_BITS-1] ? (~d + 1'b1) : d;
   endfunction

   logic v1_ff, v2_ff, v3_ff;
   logic ok2_ff, ok3_ff;
   logic ok2_in;
   logic [DIFF_BITS-1:0]   ax, ay, az;
   logic [RADIUS_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_BITS-1:0]     sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_BITS-1:0]    sum;

   // stage A: axis distances, box reject, chain check
   always_comb begin
      ax = abs_diff(query.x, rd_data.x);
      ay = abs_diff(query.y, rd_data.y);
      az = abs_diff(query.z, rd_data.z);
      ok2_in = v1_ff && (query.chain != rd_data.chain)
               && (ax <= radius) && (ay <= radius) && (az <= radius);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         ok2_ff <= 1'b0;
         ok3_ff <= 1'b0;
      end else begin
         v1_ff  <= issue;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         ok2_ff <= ok2_in;
         ok3_ff <= ok2_ff;
      end
   end

   // axes passing the box test fit the radius width
   always_ff @(posedge clock) begin
      dx_ff  <= RADIUS_BITS'(ax);
      dy_ff  <= RADIUS_BITS'(ay);
      dz_ff  <= RADIUS_BITS'(az);
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      sqz_ff <= dz_ff * dz_ff;
   end

   // stage C: sum of squares against radius squared
   assign sum = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff) + SUM_BITS'(sqz_ff);

   always_comb begin
      status.hit  = v3_ff && ok3_ff && !flush && (sum < SUM_BITS'(radius_sq));
      status.busy = v1_ff || v2_ff || v3_ff;
   end

endmodule

`default_nettype wire

@@ design/interchain_contact_detector.sv @@
// Top level of the interchain contact detector.
`default_nettype none

// Keeps up to MAX_POINTS points (x, y, z in signed fixed point with 10
// fraction bits, plus a chain number) in one single-port-read memory. A load
// word appends a point and answers with store_full set if the store was
// already full (the point is then dropped); the answer passes through the
// reply state into the response register. A clear word empties the store
// and gives no response; opcode 3 is ignored. A query word scans the stored
// points in order, one memory read per cycle through a three-stage distance
// pipeline, and stops at the first point of another chain that lies strictly
// inside contact_radius; on a miss every stored point is read. The answer
// then goes through the reply state into the response register, and with an
// empty store no read is issued at all. A stalled consumer holds the reply
// state while an earlier response still waits unread. One word is worked on
// at a time, but a new word is taken while an earlier response still waits
// in the output register. The store contents need no clearing pass after
// reset: only entries below the fill count are ever read. contact_radius
// sits at byte address 0 of the APB port (pready always high) and may only
// be written while the block is idle.
module interchain_contact_detector (
   input  logic                              clock,
   input  logic                              reset,
   icd_req_if.sink                           req_chan,
   icd_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [icd_pkg::APB_ADDR_BITS-1:0] paddr,
   input  logic [icd_pkg::APB_DATA_BITS-1:0] pwdata,
   output logic [icd_pkg::APB_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import icd_pkg::*;

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  addr_ff, addr_in;
   point_type              query_ff, query_in;
   logic                   pend_contact_ff, pend_contact_in;
   logic                   pend_full_ff, pend_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_contact_ff, rsp_contact_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [SQ_BITS-1:0]     radius_sq_ff;

   opcode_type      op;
   point_type       req_point;
   point_type       rd_data;
   pipe_status_type pipe_status;
   logic            accept;
   logic            has_room;
   logic            issue;
   logic            reply_push;
   logic            ram_wr_en;
   logic            csr_write;

   assign op        = opcode_type'(req_chan.opcode);
   assign accept    = req_chan.valid && req_chan.ready;
   assign has_room  = count_ff < COUNT_BITS'(MAX_POINTS);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      req_point.chain = req_chan.chain_number;
      req_point.x     = req_chan.coord_x;
      req_point.y     = req_chan.coord_y;
      req_point.z     = req_chan.coord_z;
   end

   // ---------------------------------------------------------------- CSR
   assign pready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      if (csr_write && (paddr[2] == REG_RADIUS)) begin
         radius_in = pwdata[RADIUS_BITS-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_RADIUS) begin
         prdata = APB_DATA_BITS'(radius_ff);
      end else begin
         prdata = '0;
      end
   end

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_LOAD:  state_in = ST_REPLY;
                  OP_QUERY: state_in = ST_SCAN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            // early exit on a hit, else wait for the last read to drain
            if (pipe_status.hit || (!issue && !pipe_status.busy)) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (reply_push) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------ outputs
   always_comb begin
      req_chan.ready = 1'b0;
      issue          = 1'b0;
      reply_push     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_SCAN:  issue = addr_ff < count_ff;
         ST_REPLY: reply_push = !rsp_valid_ff || rsp_chan.ready;
         default:  req_chan.ready = 1'b0;
      endcase
   end

   assign ram_wr_en = accept && (op == OP_LOAD) && has_room;

   // ----------------------------------------------------------- datapath
   always_comb begin
      count_in        = count_ff;
      addr_in         = addr_ff;
      query_in        = query_ff;
      pend_contact_in = pend_contact_ff;
      pend_full_in    = pend_full_ff;

      if (accept) begin
         case (op)
            OP_LOAD: begin
               pend_contact_in = 1'b0;
               pend_full_in    = !has_room;
               if (has_room) begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_QUERY: begin
               query_in        = req_point;
               addr_in         = '0;
               pend_contact_in = 1'b0;
               pend_full_in    = 1'b0;
            end
            OP_CLEAR: count_in = '0;
            default:  count_in = count_ff;
         endcase
      end

      if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
      if ((state_ff == ST_SCAN) && pipe_status.hit) begin
         pend_contact_in = 1'b1;
      end
   end

   // response register: parts the scan from a stalled consumer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_contact_in = rsp_contact_ff;
      rsp_full_in    = rsp_full_ff;
      if (reply_push) begin
         rsp_valid_in   = 1'b1;
         rsp_contact_in = pend_contact_ff;
         rsp_full_in    = pend_full_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.in_contact = rsp_contact_ff;
   assign rsp_chan.store_full = rsp_full_ff;

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff         <= addr_in;
      query_ff        <= query_in;
      pend_contact_ff <= pend_contact_in;
      pend_full_ff    <= pend_full_in;
      rsp_contact_ff  <= rsp_contact_in;
      rsp_full_ff     <= rsp_full_in;
      radius_sq_ff    <= radius_ff * radius_ff;
   end

   // ------------------------------------------------------ point store
   icd_point_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (req_point),
      .rd_en   (issue),
      .rd_addr (addr_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   icd_dist_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .flush     (state_ff != ST_SCAN),
      .issue     (issue),
      .rd_data   (rd_data),
      .query     (query_ff),
      .radius    (radius_ff),
      .radius_sq (radius_sq_ff),
      .status    (pipe_status)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_POINTS))
      else $error("fill count beyond store size");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_LOAD) && !has_room) |=> (count_ff == $past(count_ff)))
      else $error("dropped load changed the fill count");

   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= count_ff))
      else $error("scan address ran past the fill count");

   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      pipe_status.hit |-> (state_ff == ST_SCAN))
      else $error("stale hit outside a scan");

   a_reply_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_contact_ff && rsp_full_ff))
      else $error("response word with both flags set");
`endif

endmodule

`default_nettype wire
